// File: sv/m3i_pkg.sv
// Package with the shared widths, payload structs and pipeline side-band types.
`default_nettype none
package m3i_pkg;

	// Element format.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int NELEM = 9;

	// Full-width intermediate formats.
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int COF_W = 2 * DATA_WIDTH + 1;
	localparam int PART_W = 2 * DATA_WIDTH + 1;
	localparam int DET_W = 3 * DATA_WIDTH + 3;
	localparam int MAG_W = DET_W - 1;
	localparam int NUM_W = COF_W + 2 * FRAC_BITS;
	localparam int REM_W = ((NUM_W > MAG_W + DATA_WIDTH) ? NUM_W : MAG_W + DATA_WIDTH) + 1;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [PART_W-1:0] part_t;
	typedef logic signed [DET_W-1:0] det_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [REM_W-1:0] rem_t;
	typedef logic [DATA_WIDTH-1:0] quo_t;

	// Input word: one matrix, row-major.
	typedef struct packed {
		elem_t m00;
		elem_t m01;
		elem_t m02;
		elem_t m10;
		elem_t m11;
		elem_t m12;
		elem_t m20;
		elem_t m21;
		elem_t m22;
	} mat_t;

	// Output word: the inverse plus status flags.
	typedef struct packed {
		elem_t r00;
		elem_t r01;
		elem_t r02;
		elem_t r10;
		elem_t r11;
		elem_t r12;
		elem_t r20;
		elem_t r21;
		elem_t r22;
		logic  singular;
		logic  clipped;
	} inv_t;

	// Side-band that travels with the divider stages.
	typedef struct packed {
		logic [NELEM-1:0] neg;
		logic [NELEM-1:0] big;
		logic             singular;
		mag_t             dm;
	} div_side_t;

endpackage
`default_nettype wire

// File: sv/matrix3x3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse pipeline.
`default_nettype none
// Inverts one 3x3 signed Q16.16 matrix per word by the adjugate method and accepts a new
// word every cycle while mat_stall is low. The stages are the cofactor products and
// differences, the determinant split products and sum, magnitudes, the overflow check,
// one restoring-division stage per quotient bit across all nine elements, and the
// output register. Each result is truncated toward zero and saturated, with
// clipped set when any element saturates; a zero determinant gives zeros and singular.
// Stall from the output side reaches the input only when every stage holds a word, so
// empty stages keep filling while a result waits.
module matrix3x3_inverse (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           mat_valid,
	output logic                mat_stall,
	input  wire m3i_pkg::mat_t  mat,
	output logic                inv_valid,
	input  wire logic           inv_stall,
	output m3i_pkg::inv_t       inv
);
	import m3i_pkg::*;

	localparam int NS = DATA_WIDTH + 7;
	localparam int DIV0 = 6;
	localparam quo_t POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam quo_t NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic [NS-1:0] vld_in;

	cof_t  cof_c [NELEM];
	elem_t x0_c [3];
	cof_t  cof_d [NELEM];
	det_t  det_d;

	logic             det_neg;
	mag_t             dmag;
	logic [COF_W-1:0] cmag [NELEM];
	num_t             nm_s5 [NELEM];
	logic [NELEM-1:0] neg_s5;
	mag_t             dm_s5;
	logic             sing_s5;

	rem_t      rem_c [DATA_WIDTH+1][NELEM];
	quo_t      quo_c [DATA_WIDTH+1][NELEM];
	div_side_t side_c [DATA_WIDTH+1];
	rem_t      rem_s6 [NELEM];
	quo_t      quo_s6 [NELEM];
	div_side_t side_s6;

	quo_t             qf;
	logic [NELEM-1:0] over;
	elem_t            res [NELEM];
	inv_t             res_q;

	// Ready chain: a stage advances when it is empty or the next stage advances.
	assign en[NS-1] = !vld_q[NS-1] || !inv_stall;
	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	assign vld_in = {vld_q[NS-2:0], mat_valid};

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	m3i_cof u_cof (
		.clk (clk),
		.en  (en[1:0]),
		.mat (mat),
		.cof (cof_c),
		.x0  (x0_c)
	);

	m3i_det u_det (
		.clk     (clk),
		.en      (en[3:2]),
		.cof     (cof_c),
		.x0      (x0_c),
		.cof_fwd (cof_d),
		.det     (det_d)
	);

	// Signs and magnitudes of the determinant and of the scaled cofactors.
	always_comb begin
		det_neg = det_d[DET_W-1];
		dmag = det_neg ? MAG_W'(-det_d) : MAG_W'(det_d);
		for (int e = 0; e < NELEM; e++) begin
			cmag[e] = cof_d[e][COF_W-1] ? COF_W'(-cof_d[e]) : COF_W'(cof_d[e]);
		end
	end

	// Stage 5: magnitudes and result signs.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int e = 0; e < NELEM; e++) begin
				nm_s5[e] <= NUM_W'(cmag[e]) << (2 * FRAC_BITS);
				neg_s5[e] <= cof_d[e][COF_W-1] ^ det_neg;
			end
			dm_s5 <= dmag;
			sing_s5 <= (det_d == '0);
		end
	end

	// Stage 6: flag quotients wider than DATA_WIDTH bits, then seed the divider.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int e = 0; e < NELEM; e++) begin
				rem_s6[e] <= REM_W'(nm_s5[e]);
				quo_s6[e] <= '0;
				side_s6.big[e] <= REM_W'(nm_s5[e]) >= (REM_W'(dm_s5) << DATA_WIDTH);
			end
			side_s6.neg <= neg_s5;
			side_s6.singular <= sing_s5;
			side_s6.dm <= dm_s5;
		end
	end

	assign rem_c[0] = rem_s6;
	assign quo_c[0] = quo_s6;
	assign side_c[0] = side_s6;

	// Divider: one stage per quotient bit, most significant first.
	for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_div
		m3i_div_step #(
			.SHIFT (DATA_WIDTH - 1 - j)
		) u_step (
			.clk       (clk),
			.en        (en[DIV0+j]),
			.rem       (rem_c[j]),
			.quo       (quo_c[j]),
			.side      (side_c[j]),
			.rem_next  (rem_c[j+1]),
			.quo_next  (quo_c[j+1]),
			.side_next (side_c[j+1])
		);
	end

	// Sign, saturation and the singular override.
	always_comb begin
		qf = '0;
		for (int e = 0; e < NELEM; e++) begin
			qf = quo_c[DATA_WIDTH][e];
			over[e] = side_c[DATA_WIDTH].big[e]
				|| (side_c[DATA_WIDTH].neg[e] ? (qf > NEG_LIM) : (qf > POS_LIM));
			if (side_c[DATA_WIDTH].singular) begin
				res[e] = '0;
			end else if (over[e]) begin
				res[e] = side_c[DATA_WIDTH].neg[e] ? $signed(NEG_LIM) : $signed(POS_LIM);
			end else begin
				res[e] = side_c[DATA_WIDTH].neg[e] ? $signed(-qf) : $signed(qf);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			res_q.r00 <= res[0];
			res_q.r01 <= res[1];
			res_q.r02 <= res[2];
			res_q.r10 <= res[3];
			res_q.r11 <= res[4];
			res_q.r12 <= res[5];
			res_q.r20 <= res[6];
			res_q.r21 <= res[7];
			res_q.r22 <= res[8];
			res_q.singular <= side_c[DATA_WIDTH].singular;
			res_q.clipped <= !side_c[DATA_WIDTH].singular && (|over);
		end
	end

	assign inv = res_q;
	assign inv_valid = vld_q[NS-1];
	assign mat_stall = !en[0];

	// A singular result carries no clip and zeros in r00, r01, r11, r20 and r22.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |-> !inv.clipped && inv.r00 == '0 && inv.r11 == '0
			&& inv.r22 == '0 && inv.r01 == '0 && inv.r20 == '0)
		else $error("singular word with nonzero content");

	// Input is held back only by a stalled output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!inv_stall |-> !mat_stall)
		else $error("input stalled while output is free");

	// A word that was clipped shows at least one element at a limit.
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.clipped |->
			inv.r00 == $signed(POS_LIM) || inv.r00 == $signed(NEG_LIM)
			|| inv.r01 == $signed(POS_LIM) || inv.r01 == $signed(NEG_LIM)
			|| inv.r02 == $signed(POS_LIM) || inv.r02 == $signed(NEG_LIM)
			|| inv.r10 == $signed(POS_LIM) || inv.r10 == $signed(NEG_LIM)
			|| inv.r11 == $signed(POS_LIM) || inv.r11 == $signed(NEG_LIM)
			|| inv.r12 == $signed(POS_LIM) || inv.r12 == $signed(NEG_LIM)
			|| inv.r20 == $signed(POS_LIM) || inv.r20 == $signed(NEG_LIM)
			|| inv.r21 == $signed(POS_LIM) || inv.r21 == $signed(NEG_LIM)
			|| inv.r22 == $signed(POS_LIM) || inv.r22 == $signed(NEG_LIM))
		else $error("clipped word without a saturated element");

endmodule
`default_nettype wire

// File: sv/m3i_cof.sv
// Cofactor stages: eighteen products, then nine differences of two products.
`default_nettype none
module m3i_cof (
	input  wire logic                   clk,
	input  wire logic [1:0]             en,
	input  wire m3i_pkg::mat_t          mat,
	output m3i_pkg::cof_t               cof [m3i_pkg::NELEM],
	output m3i_pkg::elem_t              x0 [3]
);
	import m3i_pkg::*;

	elem_t fa [NELEM];
	elem_t fb [NELEM];
	elem_t ga [NELEM];
	elem_t gb [NELEM];
	prod_t pa_s1 [NELEM];
	prod_t pb_s1 [NELEM];
	elem_t x0_s1 [3];
	cof_t  cof_s2 [NELEM];
	elem_t x0_s2 [3];

	// Operand routing: each cofactor is fa*fb - ga*gb (rows are column cross products).
	always_comb begin
		fa[0] = mat.m11; fb[0] = mat.m22; ga[0] = mat.m21; gb[0] = mat.m12;
		fa[1] = mat.m21; fb[1] = mat.m02; ga[1] = mat.m01; gb[1] = mat.m22;
		fa[2] = mat.m01; fb[2] = mat.m12; ga[2] = mat.m11; gb[2] = mat.m02;
		fa[3] = mat.m12; fb[3] = mat.m20; ga[3] = mat.m22; gb[3] = mat.m10;
		fa[4] = mat.m22; fb[4] = mat.m00; ga[4] = mat.m02; gb[4] = mat.m20;
		fa[5] = mat.m02; fb[5] = mat.m10; ga[5] = mat.m12; gb[5] = mat.m00;
		fa[6] = mat.m10; fb[6] = mat.m21; ga[6] = mat.m20; gb[6] = mat.m11;
		fa[7] = mat.m20; fb[7] = mat.m01; ga[7] = mat.m00; gb[7] = mat.m21;
		fa[8] = mat.m00; fb[8] = mat.m11; ga[8] = mat.m10; gb[8] = mat.m01;
	end

	// Stage 1: full-width products.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int e = 0; e < NELEM; e++) begin
				pa_s1[e] <= PROD_W'(fa[e]) * PROD_W'(fb[e]);
				pb_s1[e] <= PROD_W'(ga[e]) * PROD_W'(gb[e]);
			end
			x0_s1[0] <= mat.m00;
			x0_s1[1] <= mat.m10;
			x0_s1[2] <= mat.m20;
		end
	end

	// Stage 2: differences, one bit wider than a product.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int e = 0; e < NELEM; e++) begin
				cof_s2[e] <= COF_W'(pa_s1[e]) - COF_W'(pb_s1[e]);
			end
			x0_s2 <= x0_s1;
		end
	end

	assign cof = cof_s2;
	assign x0 = x0_s2;

endmodule
`default_nettype wire

// File: sv/m3i_det.sv
// Determinant stages: split products of column 0 with the first cofactor row, then the sum.
`default_nettype none
module m3i_det (
	input  wire logic                   clk,
	input  wire logic [1:0]             en,
	input  wire m3i_pkg::cof_t          cof [m3i_pkg::NELEM],
	input  wire m3i_pkg::elem_t         x0 [3],
	output m3i_pkg::cof_t               cof_fwd [m3i_pkg::NELEM],
	output m3i_pkg::det_t               det
);
	import m3i_pkg::*;

	part_t plo_s3 [3];
	part_t phi_s3 [3];
	cof_t  cof_s3 [NELEM];
	cof_t  cof_s4 [NELEM];
	det_t  det_s4;
	det_t  det_sum;

	// Stage 3: the three first-row cofactors are split into low unsigned and high signed halves.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= PART_W'(x0[k])
					* PART_W'($signed({1'b0, cof[k][DATA_WIDTH-1:0]}));
				phi_s3[k] <= PART_W'(x0[k])
					* PART_W'($signed(cof[k][COF_W-1:DATA_WIDTH]));
			end
			cof_s3 <= cof;
		end
	end

	// Recombine the halves and add the three terms.
	always_comb begin
		det_sum = '0;
		for (int k = 0; k < 3; k++) begin
			det_sum = det_sum + (DET_W'(phi_s3[k]) <<< DATA_WIDTH) + DET_W'(plo_s3[k]);
		end
	end

	// Stage 4: determinant register.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			det_s4 <= det_sum;
			cof_s4 <= cof_s3;
		end
	end

	assign cof_fwd = cof_s4;
	assign det = det_s4;

endmodule
`default_nettype wire

// File: sv/m3i_div_step.sv
// One restoring-division stage: settles one quotient bit for all nine elements.
`default_nettype none
module m3i_div_step #(
	parameter int SHIFT = 0
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire m3i_pkg::rem_t          rem [m3i_pkg::NELEM],
	input  wire m3i_pkg::quo_t          quo [m3i_pkg::NELEM],
	input  wire m3i_pkg::div_side_t     side,
	output m3i_pkg::rem_t               rem_next [m3i_pkg::NELEM],
	output m3i_pkg::quo_t               quo_next [m3i_pkg::NELEM],
	output m3i_pkg::div_side_t          side_next
);
	import m3i_pkg::*;

	rem_t      dsh;
	rem_t      nrem [NELEM];
	quo_t      nquo [NELEM];
	rem_t      rem_s1 [NELEM];
	quo_t      quo_s1 [NELEM];
	div_side_t side_s1;

	// Trial subtract of the shifted divisor magnitude.
	always_comb begin
		dsh = rem_t'(side.dm) << SHIFT;
		for (int e = 0; e < NELEM; e++) begin
			nquo[e] = quo[e];
			if (rem[e] >= dsh) begin
				nrem[e] = rem[e] - dsh;
				nquo[e][SHIFT] = 1'b1;
			end else begin
				nrem[e] = rem[e];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= nrem;
			quo_s1 <= nquo;
			side_s1 <= side;
		end
	end

	assign rem_next = rem_s1;
	assign quo_next = quo_s1;
	assign side_next = side_s1;

endmodule
`default_nettype wire
